>>> rtl/core/cpu8_alu_with_status_flags_macros.svh
// Assertion macros used by the RTL file cpu8_alu_with_status_flags.sv.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CPU8_ALU_WITH_STATUS_FLAGS_MACROS_SVH
`define CPU8_ALU_WITH_STATUS_FLAGS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C8ALU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define C8ALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/c8alu_pkg.sv
package c8alu_pkg;

  // Command codes, in the order of the command field.
  typedef enum logic [4:0] {
    CMD_LOAD     = 5'd0,
    CMD_COMPARE  = 5'd1,
    CMD_ADC      = 5'd2,
    CMD_SBC      = 5'd3,
    CMD_OR       = 5'd4,
    CMD_AND      = 5'd5,
    CMD_XOR      = 5'd6,
    CMD_BIT      = 5'd7,
    CMD_INC      = 5'd8,
    CMD_DEC      = 5'd9,
    CMD_ASL      = 5'd10,
    CMD_LSR      = 5'd11,
    CMD_ROL      = 5'd12,
    CMD_ROR      = 5'd13,
    CMD_TRANSFER = 5'd14,
    CMD_FLAG     = 5'd15,
    CMD_PULL     = 5'd16,
    CMD_PUSH     = 5'd17
  } cmd_t;

  // Register selects for target and source.
  localparam logic [1:0] SEL_ACC = 2'd0;
  localparam logic [1:0] SEL_X   = 2'd1;
  localparam logic [1:0] SEL_Y   = 2'd2;
  localparam logic [1:0] SEL_MEM = 2'd3;

  // Flag selects for the flag write command.
  localparam logic [1:0] FSEL_C = 2'd0;
  localparam logic [1:0] FSEL_I = 2'd1;
  localparam logic [1:0] FSEL_D = 2'd2;
  localparam logic [1:0] FSEL_V = 2'd3;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [4:0] command;
    logic [7:0] operand;
    logic [1:0] target;
    logic [1:0] source;
    logic [1:0] flag_select;
    logic       flag_value;
  } item_t;

  // Architectural state: registers and the six kept flags.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic       n;
    logic       v;
    logic       d;
    logic       i;
    logic       z;
    logic       c;
  } cpu_state_t;

endpackage

>>> rtl/core/c8alu_if.sv
// Request channel: one command per beat.
interface c8alu_req_if;
  logic       valid;
  logic       ready;
  logic [4:0] command;
  logic [7:0] operand;
  logic [1:0] target;
  logic [1:0] source_sel;
  logic [1:0] flag_select;
  logic       flag_value;

  modport source (output valid, command, operand, target, source_sel, flag_select,
                  flag_value, input ready);
  modport sink (input valid, command, operand, target, source_sel, flag_select,
                flag_value, output ready);
endinterface

// Response channel: one result per beat.
interface c8alu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic [7:0] accumulator_out;
  logic [7:0] index_x_out;
  logic [7:0] index_y_out;
  logic [7:0] status_out;

  modport source (output valid, value, accumulator_out, index_x_out, index_y_out,
                  status_out, input ready);
  modport sink (input valid, value, accumulator_out, index_x_out, index_y_out,
                status_out, output ready);
endinterface

>>> rtl/core/cpu8_alu_with_status_flags.sv
// Channel | Dir | Beat carries
// req     | in  | command, operand, target, source_sel, flag_select, flag_value
// rsp     | out | value, accumulator_out, index_x_out, index_y_out, status_out
//
// A request beat passes through one input register, then the execute logic feeding
// the result register and the CPU state.
// One command per cycle is sustained while rsp is not stalled; the state loop through
// the 8-bit adder and logic unit is combinational, so back-to-back commands see each other.
// Reset clears the accumulator, both index registers, all flags and both stages.
// When rsp is stalled, both stages hold and req.ready drops once the input stage is full.
`include "cpu8_alu_with_status_flags_macros.svh"

module cpu8_alu_with_status_flags (
  input logic       clk,
  input logic       rst,
  c8alu_req_if.sink   req,
  c8alu_rsp_if.source rsp
);
  import c8alu_pkg::*;

  logic       pipe_valid;
  item_t      pipe_item;
  cpu_state_t state;
  cpu_state_t state_next;
  logic [7:0] exec_value;
  logic       advance;
  logic       exec;
  logic       res_valid;
  logic [7:0] res_value;
  logic [7:0] res_acc;
  logic [7:0] res_x;
  logic [7:0] res_y;
  logic [7:0] res_status;

  // Handshake control: the result register frees up when empty or taken.
  assign advance   = !res_valid || rsp.ready;
  assign exec      = pipe_valid && advance;
  assign req.ready = !pipe_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (req.ready) begin
      pipe_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      pipe_item <= '{command: req.command, operand: req.operand, target: req.target,
                     source: req.source_sel, flag_select: req.flag_select,
                     flag_value: req.flag_value};
    end
  end

  // Execute logic.
  c8alu_exec u_exec (
    .item       (pipe_item),
    .state      (state),
    .state_next (state_next),
    .value      (exec_value)
  );

  // CPU state updates once per executed command.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (exec) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_value  <= exec_value;
      res_acc    <= state_next.acc;
      res_x      <= state_next.x;
      res_y      <= state_next.y;
      res_status <= {state_next.n, state_next.v, 1'b1, 1'b0,
                     state_next.d, state_next.i, state_next.z, state_next.c};
    end
  end

  assign rsp.valid           = res_valid;
  assign rsp.value           = res_value;
  assign rsp.accumulator_out = res_acc;
  assign rsp.index_x_out     = res_x;
  assign rsp.index_y_out     = res_y;
  assign rsp.status_out      = res_status;

  // State only moves when a command executes.
  `C8ALU_ASSERT_NEXT(a_state_hold, !exec, state == $past(state))
  // Every executed command shows up as a response on the next cycle.
  `C8ALU_ASSERT_NEXT(a_exec_to_rsp, exec, rsp.valid)
  // An accepted request lands in the input stage.
  `C8ALU_ASSERT_NEXT(a_req_to_pipe, req.valid && req.ready, pipe_valid)
  // The reported accumulator matches the live state while a response waits and the input stage is empty.
  `C8ALU_ASSERT_SAME(a_rsp_acc, rsp.valid && !pipe_valid, rsp.accumulator_out == state.acc)

endmodule

>>> rtl/core/c8alu_exec.sv
module c8alu_exec (
  input  c8alu_pkg::item_t      item,
  input  c8alu_pkg::cpu_state_t state,
  output c8alu_pkg::cpu_state_t state_next,
  output logic [7:0]            value
);
  import c8alu_pkg::*;

  // Read a register, or the operand when memory is selected.
  function automatic logic [7:0] read_sel(input logic [1:0] sel, input cpu_state_t s,
                                          input logic [7:0] mem);
    logic [7:0] r;
    case (sel)
      SEL_ACC: r = s.acc;
      SEL_X:   r = s.x;
      SEL_Y:   r = s.y;
      default: r = mem;
    endcase
    return r;
  endfunction

  logic [7:0] op;
  logic [7:0] tgt_val;
  logic [7:0] src_val;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] diff;
  logic [7:0] res;
  logic       wr_tgt;

  assign op      = item.operand;
  assign tgt_val = read_sel(item.target, state, op);
  assign src_val = read_sel(item.source, state, op);

  // Shared adder for add and subtract; subtract adds the complement.
  assign addend = (cmd_t'(item.command) == CMD_SBC) ? ~op : op;
  assign sum    = {1'b0, state.acc} + {1'b0, addend} + {8'd0, state.c};
  assign diff   = tgt_val - op;

  // Command decode and state update.
  always_comb begin
    state_next = state;
    value      = 8'd0;
    res        = 8'd0;
    wr_tgt     = 1'b0;
    unique case (cmd_t'(item.command))
      CMD_LOAD: begin
        res    = op;
        wr_tgt = 1'b1;
      end
      CMD_COMPARE: begin
        state_next.n = diff[7];
        state_next.z = (diff == 8'd0);
        state_next.c = (tgt_val >= op);
      end
      CMD_ADC, CMD_SBC: begin
        state_next.acc = sum[7:0];
        state_next.c   = sum[8];
        state_next.v   = (state.acc[7] ^ sum[7]) & ~(state.acc[7] ^ addend[7]);
        state_next.n   = sum[7];
        state_next.z   = (sum[7:0] == 8'd0);
      end
      CMD_OR, CMD_AND, CMD_XOR: begin
        case (cmd_t'(item.command))
          CMD_OR:  state_next.acc = state.acc | op;
          CMD_AND: state_next.acc = state.acc & op;
          default: state_next.acc = state.acc ^ op;
        endcase
        state_next.n = state_next.acc[7];
        state_next.z = (state_next.acc == 8'd0);
      end
      CMD_BIT: begin
        state_next.n = op[7];
        state_next.v = op[6];
        state_next.z = ((state.acc & op) == 8'd0);
      end
      CMD_INC: begin
        res    = tgt_val + 8'd1;
        wr_tgt = 1'b1;
      end
      CMD_DEC: begin
        res    = tgt_val - 8'd1;
        wr_tgt = 1'b1;
      end
      CMD_ASL, CMD_ROL: begin
        res = {tgt_val[6:0], (cmd_t'(item.command) == CMD_ROL) & state.c};
        state_next.c = tgt_val[7];
        wr_tgt = 1'b1;
      end
      CMD_LSR, CMD_ROR: begin
        res = {(cmd_t'(item.command) == CMD_ROR) & state.c, tgt_val[7:1]};
        state_next.c = tgt_val[0];
        wr_tgt = 1'b1;
      end
      CMD_TRANSFER: begin
        res    = src_val;
        wr_tgt = 1'b1;
      end
      CMD_FLAG: begin
        case (item.flag_select)
          FSEL_C:  state_next.c = item.flag_value;
          FSEL_I:  state_next.i = item.flag_value;
          FSEL_D:  state_next.d = item.flag_value;
          default: state_next.v = item.flag_value;
        endcase
      end
      CMD_PULL: begin
        state_next.n = op[7];
        state_next.v = op[6];
        state_next.d = op[3];
        state_next.i = op[2];
        state_next.z = op[1];
        state_next.c = op[0];
      end
      CMD_PUSH: begin
        value = {state.n, state.v, 1'b1, 1'b1, state.d, state.i, state.z, state.c};
      end
      default: begin
        state_next = state;
      end
    endcase

    // Write back to the selected register or to memory, with N and Z from the byte.
    if (wr_tgt) begin
      case (item.target)
        SEL_ACC: state_next.acc = res;
        SEL_X:   state_next.x   = res;
        SEL_Y:   state_next.y   = res;
        default: value          = res;
      endcase
      state_next.n = res[7];
      state_next.z = (res == 8'd0);
    end
  end

endmodule
